@@ hdl/cbm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bank mapper.
// No dependencies; the mapper, cbm_sram and cbm_decode import this package.
package cbm_pkg;

    // Scratch RAM size (bytes); default for the top-level parameter
    localparam int RAM_BYTES_DEF = 128;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_CPU_RD  = 2'd0,
        FUNC_CPU_WR  = 2'd1,
        FUNC_PPU_XLT = 2'd2,
        FUNC_PRG_XLT = 2'd3
    } func_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VARIANT  = 2'd0,
        CFG_KEY      = 2'd1,
        CFG_PRG_MASK = 2'd2,
        CFG_CHR_MASK = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_W = 8;

    // Configuration reset values
    localparam logic       RST_VARIANT  = 1'b0;
    localparam logic [7:0] RST_KEY      = 8'hA3;
    localparam logic [7:0] RST_PRG_MASK = 8'h1F;
    localparam logic [7:0] RST_CHR_MASK = 8'hFF;

    // Address windows
    localparam logic [7:0]  RAM_PAGE   = 8'h7F;     // 0x7F00-0x7FFF
    localparam logic [11:0] REG_WINDOW = 12'h7EF;   // 0x7EF0-0x7EFF

    typedef struct packed {
        logic       variant;
        logic [7:0] unlock_key;
        logic [7:0] prg_bank_mask;
        logic [7:0] chr_bank_mask;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_claimed;
        logic [17:0] chr_address;
        logic [20:0] prg_address;
        logic        nametable_page;
    } rsp_t;

endpackage

@@ hdl/cbm_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: bus access or translation query, valid/ready handshake.
// Standalone interface, no package dependency.
interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, func, bus_address, write_data, input ready);
    modport sink   (input valid, func, bus_address, write_data, output ready);
endinterface

@@ hdl/cbm_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: one result beat per request, valid/ready handshake.
// Standalone interface, no package dependency.
interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        read_claimed;
    logic [17:0] chr_address;
    logic [20:0] prg_address;
    logic        nametable_page;

    modport source (output valid, read_data, read_claimed, chr_address, prg_address,
                    nametable_page, input ready);
    modport sink   (input valid, read_data, read_claimed, chr_address, prg_address,
                    nametable_page, output ready);
endinterface

@@ hdl/cartridge_bank_mapper_secured_ram_unit.sv @@
`timescale 1ns / 1ps
// Cartridge bank mapper with key-locked 128-byte RAM. Accepts one request beat
// per clock unless the response channel stalls, and returns one result beat per
// request, in order, via the request register (with the RAM read), then the
// result register. The RAM is a single synchronous memory, read registered; a
// write commits as its item leaves the execute stage and a later read of the same
// byte is forwarded, so back-to-back accesses never stall. Per-byte valid bits make
// RAM contents read as zero after reset: no clearing pass, ready right after reset.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if, cbm_sram and cbm_decode.
module cartridge_bank_mapper_secured_ram_unit
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cbm_req_if.sink               req,
    cbm_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(RAM_BYTES);

    cfg_t cfg_reg;

    logic        s1_vld_reg;
    logic [1:0]  s1_func_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;
    logic        out_vld_reg;
    rsp_t        out_data_reg;

    logic          in_acc;
    logic          s1_adv;
    logic          out_free;
    logic [7:0]    ram_rd_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    rsp_t          s1_rsp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.variant       <= RST_VARIANT;
            cfg_reg.unlock_key    <= RST_KEY;
            cfg_reg.prg_bank_mask <= RST_PRG_MASK;
            cfg_reg.chr_bank_mask <= RST_CHR_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_VARIANT:  cfg_reg.variant       <= cfg_wdata[0];
                CFG_KEY:      cfg_reg.unlock_key    <= cfg_wdata;
                CFG_PRG_MASK: cfg_reg.prg_bank_mask <= cfg_wdata;
                CFG_CHR_MASK: cfg_reg.chr_bank_mask <= cfg_wdata;
                default:      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Handshake / pipeline control
    assign out_free  = !out_vld_reg || rsp.ready;
    assign s1_adv    = s1_vld_reg && out_free;
    assign req.ready = !s1_vld_reg || out_free;
    assign in_acc    = req.valid && req.ready;

    // Execute stage: request register (RAM read issued on accept)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_func_reg <= req.func;
            s1_addr_reg <= req.bus_address;
            s1_data_reg <= req.write_data;
        end
    end

    cbm_sram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_sram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (req.bus_address[AW-1:0]),
        .rd_data (ram_rd_data),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata)
    );

    cbm_decode #(
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .commit      (s1_adv),
        .func        (s1_func_reg),
        .bus_address (s1_addr_reg),
        .write_data  (s1_data_reg),
        .ram_rd_data (ram_rd_data),
        .ram_we      (ram_we),
        .ram_addr    (ram_waddr),
        .ram_wdata   (ram_wdata),
        .rsp         (s1_rsp)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= s1_rsp;
        end
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.read_data      = out_data_reg.read_data;
    assign rsp.read_claimed   = out_data_reg.read_claimed;
    assign rsp.chr_address    = out_data_reg.chr_address;
    assign rsp.prg_address    = out_data_reg.prg_address;
    assign rsp.nametable_page = out_data_reg.nametable_page;

`ifndef NO_ASSERTIONS
    // A stalled execute stage blocks new requests
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !out_free) |-> !in_acc)
        else $error("request accepted over a stalled item");
    // Every accepted beat occupies the execute stage next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_vld_reg)
        else $error("accepted request lost");
    // Every item leaving execute becomes a pending result
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_vld_reg)
        else $error("executed item produced no result");
`endif

endmodule

@@ hdl/cbm_sram.sv @@
`timescale 1ns / 1ps
// Secured scratch RAM: synchronous memory, registered read, per-entry valid
// bits for the zero reset, and write-to-read forwarding. Uses cbm_pkg.
module cbm_sram
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF,
    localparam int AW = $clog2(RAM_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0]           mem [RAM_BYTES];
    logic [7:0]           rdata_reg;
    logic [AW-1:0]        raddr_reg;
    logic [RAM_BYTES-1:0] vld_reg;
    logic                 fwd_vld_reg;
    logic [AW-1:0]        fwd_addr_reg;
    logic [7:0]           fwd_data_reg;

    // Memory array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            raddr_reg <= rd_addr;
        end
    end

    // Entry valid bits: unwritten entries read as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Last write, covers a read issued on the same edge as that write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // Read data select
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == raddr_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (!vld_reg[raddr_reg])
        begin
            rd_data = 8'h00;
        end
        else
        begin
            rd_data = rdata_reg;
        end
    end

endmodule

@@ hdl/cbm_decode.sv @@
`timescale 1ns / 1ps
// Bank/latch/mirror registers, CPU write decode and address translation.
// Builds the result for the item in the execute stage. Uses cbm_pkg.
module cbm_decode
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF,
    localparam int AW = $clog2(RAM_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          commit,
    input  logic [1:0]    func,
    input  logic [15:0]   bus_address,
    input  logic [7:0]    write_data,
    input  logic [7:0]    ram_rd_data,
    output logic          ram_we,
    output logic [AW-1:0] ram_addr,
    output logic [7:0]    ram_wdata,
    output rsp_t          rsp
);

    logic [7:0] chr_bank_reg  [6];
    logic [7:0] chr_bank_next [6];
    logic [7:0] prg_bank_reg  [3];
    logic [7:0] prg_bank_next [3];
    logic [7:0] latch_reg, latch_next;
    logic       mirror_reg, mirror_next;

    logic        unlocked;
    logic        in_ram, in_regs;
    logic        is_write;
    logic [13:0] ppu_a;
    logic [7:0]  chr_bank;
    logic [7:0]  prg_bank;
    logic [1:0]  prg_slot;

    assign unlocked  = (latch_reg == cfg.unlock_key);
    assign in_ram    = (bus_address[15:8] == RAM_PAGE);
    assign in_regs   = (bus_address[15:4] == REG_WINDOW);
    assign is_write  = commit && (func_t'(func) == FUNC_CPU_WR);
    assign ppu_a     = bus_address[13:0];
    assign prg_slot  = bus_address[14:13];

    // RAM write port
    assign ram_we    = is_write && in_ram && unlocked;
    assign ram_addr  = bus_address[AW-1:0];
    assign ram_wdata = write_data;

    // CHR bank lookup: 2K pairs below 0x1000, 1K banks above
    always_comb
    begin
        if (!ppu_a[12])
        begin
            chr_bank = {chr_bank_reg[{2'b00, ppu_a[11]}][7:1], ppu_a[10]};
        end
        else
        begin
            chr_bank = chr_bank_reg[{1'b0, ppu_a[11:10]} + 3'd2];
        end
    end

    // PRG bank lookup: last slot fixed to the last bank
    assign prg_bank = (prg_slot == 2'd3) ? cfg.prg_bank_mask
                                         : (prg_bank_reg[prg_slot] & cfg.prg_bank_mask);

    // Result for the current item
    always_comb
    begin
        rsp = '0;
        case (func_t'(func))
            FUNC_CPU_RD:
            begin
                if (in_ram)
                begin
                    rsp.read_data    = unlocked ? ram_rd_data : bus_address[15:8];
                    rsp.read_claimed = 1'b1;
                end
                else if (in_regs && (bus_address[3:1] == 3'b100))
                begin
                    rsp.read_data    = latch_reg;
                    rsp.read_claimed = 1'b1;
                end
            end
            FUNC_CPU_WR:
            begin
                rsp = '0;
            end
            FUNC_PPU_XLT:
            begin
                if (!ppu_a[13])
                begin
                    rsp.chr_address = {chr_bank & cfg.chr_bank_mask, ppu_a[9:0]};
                end
                else if (cfg.variant)
                begin
                    rsp.nametable_page = mirror_reg;
                end
                else
                begin
                    rsp.nametable_page = mirror_reg ? ppu_a[10] : ppu_a[11];
                end
            end
            FUNC_PRG_XLT:
            begin
                if (bus_address[15])
                begin
                    rsp.prg_address = {prg_bank, bus_address[12:0]};
                end
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

    // Register-window write decode
    always_comb
    begin
        chr_bank_next = chr_bank_reg;
        prg_bank_next = prg_bank_reg;
        latch_next    = latch_reg;
        mirror_next   = mirror_reg;
        if (is_write && in_regs)
        begin
            case (bus_address[3:0])
                4'h0, 4'h1:
                begin
                    chr_bank_next[{2'b00, bus_address[0]}] = write_data;
                    if (cfg.variant)
                    begin
                        mirror_next = write_data[7];
                    end
                end
                4'h2, 4'h3, 4'h4, 4'h5:
                begin
                    chr_bank_next[bus_address[2:0]] = write_data;
                    if (cfg.variant)
                    begin
                        mirror_next = write_data[7];
                    end
                end
                4'h6, 4'h7:
                begin
                    if (!cfg.variant)
                    begin
                        mirror_next = write_data[0];
                    end
                end
                4'h8, 4'h9:
                begin
                    latch_next = write_data;
                end
                4'hA, 4'hB:
                begin
                    prg_bank_next[0] = write_data;
                end
                4'hC, 4'hD:
                begin
                    prg_bank_next[1] = write_data;
                end
                default:
                begin
                    prg_bank_next[2] = write_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                chr_bank_reg[i] <= 8'h00;
            end
            for (int i = 0; i < 3; i++)
            begin
                prg_bank_reg[i] <= 8'h00;
            end
            latch_reg  <= 8'h00;
            mirror_reg <= 1'b0;
        end
        else
        begin
            chr_bank_reg <= chr_bank_next;
            prg_bank_reg <= prg_bank_next;
            latch_reg    <= latch_next;
            mirror_reg   <= mirror_next;
        end
    end

`ifndef NO_ASSERTIONS
    // RAM is only written through an unlocked CPU write in the RAM window
    a_ram_we_locked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (latch_reg == cfg.unlock_key) && in_ram && commit)
        else $error("RAM write while locked or outside window");
    // Latch changes only on a committed write to its register pair
    a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(is_write && in_regs && (bus_address[3:1] == 3'b100)) |=> $stable(latch_reg))
        else $error("security latch changed without a latch write");
    // Last PRG slot always maps to the mask
    a_prg_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (prg_slot == 2'd3) |-> (prg_bank == cfg.prg_bank_mask))
        else $error("fixed PRG slot misdecoded");
`endif

endmodule
